// ----- hw/rtl/pptb_pkg.sv -----
// Package for the packed-pixel to bit-plane converter.
// Holds the job and queue status types and the fixed constants; no dependencies.
package pptb_pkg;

  localparam int unsigned NumPlanes = 4;
  localparam int unsigned OffsetW   = 17;
  localparam int unsigned RowW      = 9;
  localparam int unsigned JobDepth  = 2;

  localparam logic [OffsetW-1:0] LineDown = 17'h00080;
  localparam logic [63:0]        MapReset = 64'hFEDCBA9876543210;

  typedef struct packed {
    logic [NumPlanes-1:0][7:0] planes;
    logic [OffsetW-1:0]        base;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- hw/rtl/packed_pixel_to_bitplane_core.sv -----
// Packed-pixel to bit-plane converter, top level; uses pptb_pkg, pptb_front,
// pptb_fifo and pptb_back.
// Flow: the second byte of a pair pushes a job into the job queue, from which the
//   output register loads the job's eight writes one per cycle while pop is held.
// The two-entry job queue holds the job being written and one more, so the front
//   can run ahead by one pair.
// Reset: rst_ni clears position, phase, queue and output valid at once and
//   restores the identity colour table.
module packed_pixel_to_bitplane_core #(
  parameter int unsigned COLUMNS_PER_ROW = 32,
  parameter int unsigned ROW_PITCH       = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel_pair_i,
  // colour table register
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_data_i,
  // plane writes, queue style
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  plane_o,
  output logic [16:0] offset_o,
  output logic [7:0]  plane_byte_o,
  output logic        last_o
);
  import pptb_pkg::*;

  job_t        job_in, job_out;
  queue_stat_t q_stat;
  logic        job_push, job_pop;

  // Front: pair bytes, remap, transpose, compute the base offset.
  pptb_front #(
    .COLUMNS_PER_ROW(COLUMNS_PER_ROW),
    .ROW_PITCH      (ROW_PITCH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .pixel_pair_i(pixel_pair_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  // Hold finished jobs so front and back can stall independently.
  pptb_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(job_push),
    .data_i(job_in),
    .pop_i (job_pop),
    .data_o(job_out),
    .stat_o(q_stat)
  );

  // Back: issue the eight writes of each job, drop the job after the last.
  pptb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .q_stat_i    (q_stat),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .plane_o     (plane_o),
    .offset_o    (offset_o),
    .plane_byte_o(plane_byte_o),
    .last_o      (last_o)
  );

endmodule

// ----- hw/rtl/pptb_front.sv -----
// Front end: accepts pixel bytes, pairs them, remaps and transposes to plane bytes.
// Depends on pptb_pkg; keeps the colour table and the column and row position.
module pptb_front #(
  parameter int unsigned COLUMNS_PER_ROW = 32,
  parameter int unsigned ROW_PITCH       = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          pixel_pair_i,
  input  logic                cfg_we_i,
  input  logic [63:0]         cfg_data_i,
  input  pptb_pkg::queue_stat_t q_stat_i,
  output logic                job_push_o,
  output pptb_pkg::job_t      job_o
);
  import pptb_pkg::*;

  localparam int unsigned ColW = (COLUMNS_PER_ROW > 1) ? $clog2(COLUMNS_PER_ROW) : 1;

  logic [63:0]        color_map_q;
  logic [7:0]         held_q;
  logic [1:0]         phase_q;
  logic [ColW-1:0]    column_q, column_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [OffsetW-1:0] row_base_q, row_base_d;
  logic               accept;
  logic [3:0]         pix [4];

  function automatic logic [3:0] remap(logic [63:0] map, logic [3:0] code);
    return map[{code, 2'b00} +: 4];
  endfunction

  // Hold off only on the second byte of a pair when the job queue has no room.
  assign full       = phase_q[0] & q_stat_i.full;
  assign accept     = push & ~full;
  assign job_push_o = accept & phase_q[0];

  assign pix[0] = remap(color_map_q, held_q[7:4]);
  assign pix[1] = remap(color_map_q, held_q[3:0]);
  assign pix[2] = remap(color_map_q, pixel_pair_i[7:4]);
  assign pix[3] = remap(color_map_q, pixel_pair_i[3:0]);

  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      job_o.planes[p] = {pix[0][p], pix[0][p], pix[1][p], pix[1][p],
                         pix[2][p], pix[2][p], pix[3][p], pix[3][p]};
    end
    job_o.base = row_base_q + OffsetW'({column_q, 1'b0}) + OffsetW'(phase_q[1]);
  end

  // Advance column after the fourth byte; wrap it and step the row base.
  always_comb begin
    column_d   = column_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    if (column_q == ColW'(COLUMNS_PER_ROW - 1)) begin
      column_d = '0;
      row_d    = row_q + 1'b1;
      if (row_q == {RowW{1'b1}}) begin
        row_base_d = '0;
      end else begin
        row_base_d = row_base_q + OffsetW'(ROW_PITCH);
      end
    end else begin
      column_d = column_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_map_q <= MapReset;
      held_q      <= '0;
      phase_q     <= '0;
      column_q    <= '0;
      row_q       <= '0;
      row_base_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        color_map_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q <= phase_q + 1'b1;
        if (!phase_q[0]) begin
          held_q <= pixel_pair_i;
        end
        if (phase_q == 2'd3) begin
          column_q   <= column_d;
          row_q      <= row_d;
          row_base_q <= row_base_d;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/pptb_fifo.sv -----
// Two-entry job queue between the front end and the write sequencer.
// Depends on pptb_pkg for the job and status types.
module pptb_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pptb_pkg::job_t        data_i,
  input  logic                  pop_i,
  output pptb_pkg::job_t        data_o,
  output pptb_pkg::queue_stat_t stat_o
);
  import pptb_pkg::*;

  localparam int unsigned PtrW = $clog2(JobDepth);

  job_t              mem_q [JobDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == (PtrW + 1)'(JobDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/pptb_back.sv -----
// Write sequencer: turns one job into eight plane writes into an output register.
// Depends on pptb_pkg for the job type and constants.
module pptb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pptb_pkg::job_t        job_i,
  input  pptb_pkg::queue_stat_t q_stat_i,
  output logic                  job_pop_o,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            plane_o,
  output logic [16:0]           offset_o,
  output logic [7:0]            plane_byte_o,
  output logic                  last_o
);
  import pptb_pkg::*;

  logic [2:0] seq_q;
  logic       out_valid_q, out_valid_d;
  logic       load;

  assign empty     = ~out_valid_q;
  assign load      = ~q_stat_i.empty & (~out_valid_q | pop);
  assign job_pop_o = load & (seq_q == 3'd7);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        seq_q <= seq_q + 1'b1;
      end
    end
  end

  // Even step writes at the base, odd step one line lower.
  always_ff @(posedge clk_i) begin
    if (load) begin
      plane_o      <= seq_q[2:1];
      offset_o     <= job_i.base + (seq_q[0] ? LineDown : '0);
      plane_byte_o <= job_i.planes[seq_q[2:1]];
      last_o       <= (seq_q == 3'd7);
    end
  end

endmodule

// ----- hw/rtl/pptb_checker.sv -----
// Port-level checker for the packed-pixel to bit-plane converter, bound to the top.
// Depends only on the top level's ports.
module pptb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  plane_o,
  input logic [16:0] offset_o,
  input logic [7:0]  plane_byte_o,
  input logic        last_o
);

  // Output register is empty while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result pending during reset");

  // A waiting write holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(plane_o) && $stable(offset_o)
                          && $stable(plane_byte_o) && $stable(last_o)))
    else $error("waiting write changed");

  // Writes of a burst follow back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("gap inside a burst");

  // Plane index stays or steps by one within a burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=>
      (plane_o == $past(plane_o) || plane_o == 2'($past(plane_o) + 2'd1)))
    else $error("plane order broken");

  // Input only backs up when writes are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !empty)
    else $error("input stalled with no pending writes");

endmodule

bind packed_pixel_to_bitplane_core pptb_checker u_pptb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .plane_o     (plane_o),
  .offset_o    (offset_o),
  .plane_byte_o(plane_byte_o),
  .last_o      (last_o)
);
